>>> hw/rtl/ext_hash_directory_engine_unit_assert.svh
// Assertion macros shared by the directory engine RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef EXT_HASH_DIRECTORY_ENGINE_UNIT_ASSERT_SVH
`define EXT_HASH_DIRECTORY_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define EHD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define EHD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/ehd_pkg.sv
// Package for the extendible-hashing directory engine: sizes, codes, word types.
// No dependencies; imported by the top level and the sequencer.
package ehd_pkg;

  localparam int GROUP_BITS   = 4;
  localparam int MAX_DIR_BITS = 10;

  localparam int SEG_W    = 32;
  localparam int DEPTH_W  = 5;
  localparam int NODE_W   = 4;
  localparam int FUNC_W   = 2;
  localparam int ADDR_W   = MAX_DIR_BITS;
  localparam int DIR_SIZE = 1 << MAX_DIR_BITS;
  // counters that must hold the directory size itself
  localparam int CNT_W    = ADDR_W + 1;

  localparam int DEPTH_SUM = GROUP_BITS + MAX_DIR_BITS;
  localparam logic [DEPTH_W-1:0] DEPTH_CAP =
    DEPTH_W'((DEPTH_SUM > 31) ? 31 : DEPTH_SUM);
  localparam logic [DEPTH_W-1:0] GROUP_DEPTH = DEPTH_W'(GROUP_BITS);

  // live entries right after reset (global depth equals GROUP_BITS)
  localparam int INIT_SIZE = 1;

  // request function codes
  localparam logic [FUNC_W-1:0] FUNC_SPLIT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_EXPAND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

  // status codes
  localparam logic STATUS_DONE   = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [ADDR_W-1:0]  entry_index;
    logic [SEG_W-1:0]   segment_a;
    logic [SEG_W-1:0]   segment_b;
    logic [DEPTH_W-1:0] local_depth;
    logic [DEPTH_W-1:0] target_depth;
  } req_word_t;

  typedef struct packed {
    logic               status;
    logic [SEG_W-1:0]   read_segment;
    logic [DEPTH_W-1:0] read_depth;
    logic [NODE_W-1:0]  read_node;
    logic [DEPTH_W-1:0] current_depth;
  } rsp_word_t;

  // one directory entry as stored in memory
  typedef struct packed {
    logic [SEG_W-1:0]   segment;
    logic [DEPTH_W-1:0] depth;
    logic [NODE_W-1:0]  node;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam entry_t RESET_ENTRY = '{segment: '0, depth: GROUP_DEPTH, node: '0};

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPL_RD,
    ST_SPL_WR,
    ST_EXP_RD,
    ST_EXP_WR,
    ST_ENT_RD,
    ST_FINISH
  } state_t;

  // memory commands from the sequencer; bank picks one of the two copies
  typedef struct packed {
    logic              rd_en;
    logic              rd_bank;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic              wr_bank;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
  } ctrl_mem_t;

  typedef struct packed {
    logic      load;
    rsp_word_t word;
  } ctrl_rsp_t;

  // live directory entries at global depth g
  function automatic logic [CNT_W-1:0] live_size(input logic [DEPTH_W-1:0] g);
    logic [DEPTH_W-1:0] e;
    begin
      e = (g >= GROUP_DEPTH) ? g - GROUP_DEPTH : '0;
      if (e > DEPTH_W'(MAX_DIR_BITS)) e = DEPTH_W'(MAX_DIR_BITS);
      return CNT_W'(1) << e;
    end
  endfunction

endpackage

>>> hw/rtl/ext_hash_directory_engine_unit.sv
// Top level of the extendible-hashing directory engine.
// Depends on ehd_pkg, ehd_ram (two directory banks) and ehd_ctrl.

// One request word at a time. A split writes one directory entry per cycle.
// An expand walks the old directory run by run: one read per run plus one
// write per new entry. The directory lives in two banks; an expand builds
// the new directory in the idle bank and then swaps, and each bank has a
// single write port. After reset a clearing pass initializes the live entry
// before the first request is taken.
// A new request is accepted while the previous result still waits on rsp.
module ext_hash_directory_engine_unit import ehd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_word_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_word_t rsp
);

  ctrl_mem_t        mem;
  ctrl_rsp_t        rsp_cmd;
  entry_t           rdata;
  logic             busy;
  logic             out_free;
  logic             rd_bank;
  logic [ENTRY_W-1:0] q0;
  logic [ENTRY_W-1:0] q1;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = busy;

  ehd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .rdata     (rdata),
    .out_free  (out_free),
    .busy      (busy),
    .mem       (mem),
    .rsp_cmd   (rsp_cmd)
  );

  // directory bank 0
  ehd_ram #(.WIDTH(ENTRY_W), .DEPTH(DIR_SIZE)) u_bank0 (
    .clk   (clk),
    .we    (mem.wr_en && !mem.wr_bank),
    .waddr (mem.wr_addr),
    .wdata (mem.wr_data),
    .re    (mem.rd_en && !mem.rd_bank),
    .raddr (mem.rd_addr),
    .rdata (q0)
  );

  // directory bank 1
  ehd_ram #(.WIDTH(ENTRY_W), .DEPTH(DIR_SIZE)) u_bank1 (
    .clk   (clk),
    .we    (mem.wr_en && mem.wr_bank),
    .waddr (mem.wr_addr),
    .wdata (mem.wr_data),
    .re    (mem.rd_en && mem.rd_bank),
    .raddr (mem.rd_addr),
    .rdata (q1)
  );

  // remember which bank the last read came from
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_bank <= 1'b0;
    end else if (mem.rd_en) begin
      rd_bank <= mem.rd_bank;
    end
  end

  assign rdata = rd_bank ? entry_t'(q1) : entry_t'(q0);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_cmd.load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_cmd.load) begin
      rsp <= rsp_cmd.word;
    end
  end

endmodule

>>> hw/rtl/ehd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; used for both directory banks.
module ehd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/ehd_ctrl.sv
// Sequencer of the directory engine: request checks, split fill, expand copy, reads.
// Depends on ehd_pkg and the assertion macro header.
`include "ext_hash_directory_engine_unit_assert.svh"

module ehd_ctrl import ehd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  req_word_t req,
  input  entry_t    rdata,
  input  logic      out_free,
  output logic      busy,
  output ctrl_mem_t mem,
  output ctrl_rsp_t rsp_cmd
);

  state_t state, state_next;

  logic               bank;
  logic [DEPTH_W-1:0] gdepth;
  req_word_t          cur;
  logic               status;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   kcnt;
  logic [CNT_W-1:0]   pptr;
  logic [CNT_W-1:0]   run;
  logic [CNT_W-1:0]   osize;
  logic [CNT_W-1:0]   nsize;

  // request checks against the current global depth
  logic [CNT_W-1:0]   size_now;
  logic [CNT_W-1:0]   idx_w;
  logic [DEPTH_W-1:0] spl_shift;
  logic [CNT_W-1:0]   spl_run;
  logic [CNT_W-1:0]   spl_mask;
  logic               spl_bad;
  logic               exp_bad;
  logic               rd_bad;
  logic               req_ok;
  logic               accept;

  assign accept    = req_valid && (state == ST_IDLE);
  assign size_now  = live_size(gdepth);
  assign idx_w     = CNT_W'(req.entry_index);
  assign spl_shift = gdepth - req.local_depth;
  assign spl_run   = CNT_W'(1) << spl_shift;
  assign spl_mask  = spl_run - CNT_W'(1);

  assign spl_bad = (req.local_depth < GROUP_DEPTH) || (req.local_depth >= gdepth) ||
                   ((req.entry_index & spl_mask[ADDR_W-1:0]) != '0) ||
                   (idx_w >= size_now) || (spl_run > (size_now - idx_w));
  assign exp_bad = (req.target_depth < gdepth) || (req.target_depth > DEPTH_CAP);
  assign rd_bad  = idx_w >= size_now;

  always_comb begin
    case (req.func)
      FUNC_SPLIT:  req_ok = !spl_bad;
      FUNC_EXPAND: req_ok = !exp_bad;
      FUNC_READ:   req_ok = !rd_bad;
      default:     req_ok = 1'b0;
    endcase
  end

  // expand step: clamp the old entry's depth, size its copy count and stride
  logic [DEPTH_W-1:0] d_clamp;
  logic [CNT_W-1:0]   exp_num;
  logic [CNT_W-1:0]   exp_step;
  logic [CNT_W-1:0]   p_next;
  logic               q_last;
  logic               exp_last_k;
  logic               exp_end;

  always_comb begin
    d_clamp = rdata.depth;
    if (d_clamp < GROUP_DEPTH) d_clamp = GROUP_DEPTH;
    if (d_clamp > gdepth) d_clamp = gdepth;
  end

  assign exp_num    = CNT_W'(1) << (cur.target_depth - d_clamp);
  assign exp_step   = CNT_W'(1) << (gdepth - d_clamp);
  assign p_next     = pptr + exp_step;
  assign q_last     = (cnt + CNT_W'(1)) == nsize;
  assign exp_last_k = ((kcnt + CNT_W'(1)) == exp_num) || q_last;
  assign exp_end    = exp_last_k && ((p_next >= osize) || q_last);

  // split step
  logic spl_last;
  logic spl_low;

  assign spl_last = cnt == (run - CNT_W'(1));
  assign spl_low  = cnt < (run >> 1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (cnt == CNT_W'(INIT_SIZE - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          if (!req_ok) begin
            state_next = ST_FINISH;
          end else begin
            case (req.func)
              FUNC_SPLIT:  state_next = ST_SPL_RD;
              FUNC_EXPAND: state_next = ST_EXP_RD;
              default:     state_next = ST_ENT_RD;
            endcase
          end
        end
      end
      ST_SPL_RD: state_next = ST_SPL_WR;
      ST_SPL_WR: begin
        if (spl_last) state_next = ST_FINISH;
      end
      ST_EXP_RD: state_next = ST_EXP_WR;
      ST_EXP_WR: begin
        if (exp_end) begin
          state_next = ST_FINISH;
        end else if (exp_last_k) begin
          state_next = ST_EXP_RD;
        end
      end
      ST_ENT_RD: state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state, depth and bank select
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      bank   <= 1'b0;
      gdepth <= GROUP_DEPTH;
      cnt    <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_CLEAR: cnt <= cnt + CNT_W'(1);
        ST_IDLE: begin
          if (accept) begin
            cnt <= '0;
          end
        end
        ST_SPL_WR: cnt <= cnt + CNT_W'(1);
        ST_EXP_WR: begin
          cnt <= cnt + CNT_W'(1);
          if (exp_end) begin
            gdepth <= cur.target_depth;
            bank   <= ~bank;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // request context and walk pointers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cur    <= req;
          status <= req_ok ? STATUS_DONE : STATUS_REJECT;
          pptr   <= '0;
          run    <= spl_run;
          osize  <= size_now;
          nsize  <= live_size(req.target_depth);
        end
      end
      ST_EXP_RD: kcnt <= '0;
      ST_EXP_WR: begin
        kcnt <= kcnt + CNT_W'(1);
        if (exp_last_k) pptr <= p_next;
      end
      default: begin
      end
    endcase
  end

  // memory commands and result
  always_comb begin
    mem             = '0;
    mem.rd_bank     = bank;
    mem.wr_bank     = bank;
    rsp_cmd         = '0;
    case (state)
      ST_CLEAR: begin
        mem.wr_en   = 1'b1;
        mem.wr_addr = cnt[ADDR_W-1:0];
        mem.wr_data = RESET_ENTRY;
      end
      ST_SPL_RD: begin
        mem.rd_en   = 1'b1;
        mem.rd_addr = cur.entry_index;
      end
      ST_SPL_WR: begin
        mem.wr_en           = 1'b1;
        mem.wr_addr         = cur.entry_index + cnt[ADDR_W-1:0];
        mem.wr_data.segment = spl_low ? cur.segment_a : cur.segment_b;
        mem.wr_data.depth   = cur.local_depth + DEPTH_W'(1);
        mem.wr_data.node    = rdata.node;
      end
      ST_EXP_RD: begin
        mem.rd_en   = 1'b1;
        mem.rd_addr = pptr[ADDR_W-1:0];
      end
      ST_EXP_WR: begin
        // new directory goes to the other bank
        mem.wr_en   = 1'b1;
        mem.wr_bank = ~bank;
        mem.wr_addr = cnt[ADDR_W-1:0];
        mem.wr_data = rdata;
      end
      ST_ENT_RD: begin
        mem.rd_en   = 1'b1;
        mem.rd_addr = cur.entry_index;
      end
      ST_FINISH: begin
        rsp_cmd.load               = out_free;
        rsp_cmd.word.status        = status;
        rsp_cmd.word.current_depth = gdepth;
        if ((status == STATUS_DONE) && (cur.func == FUNC_READ)) begin
          rsp_cmd.word.read_segment = rdata.segment;
          rsp_cmd.word.read_depth   = rdata.depth;
          rsp_cmd.word.read_node    = rdata.node;
        end
      end
      default: begin
      end
    endcase
  end

  assign busy = state != ST_IDLE;

  `EHD_ASSERT_IMPL(a_split_live, clk, rst, state == ST_SPL_WR,
    (CNT_W'(cur.entry_index) + cnt) < live_size(gdepth), "split write past live directory")
  `EHD_ASSERT_IMPL(a_expand_bound, clk, rst, state == ST_EXP_WR,
    cnt < nsize, "expand write past new directory")
  `EHD_ASSERT_NEXT(a_depth_grows, clk, rst, state != ST_CLEAR,
    gdepth >= $past(gdepth), "global depth went down")
  `EHD_ASSERT_IMPL(a_depth_cap, clk, rst, state != ST_CLEAR,
    (gdepth <= DEPTH_CAP) && (gdepth >= GROUP_DEPTH), "global depth out of range")

endmodule
